// ===== design/first_fit_span_allocator_core_assert.svh =====
// Assertion macros shared by the span allocator RTL
`ifndef FIRST_FIT_SPAN_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_SPAN_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define FFSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define FFSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ffsa_pkg.sv =====
// Shared types and constants for the first-fit span allocator
package ffsa_pkg;

	localparam int FIELD_W  = 24;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NO_FIT     = 2'd1,
		ST_TABLE_FULL = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_APPLY,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_RESP
	} state_t;

	// table update chosen after the scan
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_WRITE,
		ACT_WRITE_DEL,
		ACT_DEL,
		ACT_INS
	} act_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic decide;
		logic apply;
		logic shift_dn;
		logic shift_up;
		logic load_out;
	} ffsa_cmd_t;

	typedef struct packed {
		logic bypass;
		logic scan_done;
		act_t act;
		logic shift_done;
		logic out_free;
	} ffsa_stat_t;

endpackage

// ===== design/ffsa_if.sv =====
// Request and response channel interfaces of the span allocator
interface ffsa_req_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [ffsa_pkg::FIELD_W-1:0]     span_start;
	logic [ffsa_pkg::FIELD_W-1:0]     span_length;

	modport source (output valid, mode, span_start, span_length, input ready);
	modport sink   (input valid, mode, span_start, span_length, output ready);
endinterface

interface ffsa_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ffsa_pkg::FIELD_W-1:0]     granted_start;
	logic [ffsa_pkg::STATUS_W-1:0]    status;

	modport source (output valid, granted_start, status, input ready);
	modport sink   (input valid, granted_start, status, output ready);
endinterface

// ===== design/first_fit_span_allocator_core.sv =====
// Top level of the first-fit span allocator with coalescing free list
//
//  channel | dir | payload                          | handshake
//  req     | in  | mode, span_start, span_length    | valid / ready
//  rsp     | out | granted_start, status            | valid / ready
//
// One request at a time. The scan reads one table entry per cycle up to the match or insert
// position, and an insert or removal then moves each entry behind it, one per cycle, through
// the same port. A free of length zero goes straight from the scan to the response.
// Reset empties the table at once. A finished response waits in the output register while
// the next request is taken.

`include "first_fit_span_allocator_core_assert.svh"

module first_fit_span_allocator_core #(
	parameter int MAX_SPANS  = 64,
	parameter int INDEX_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	ffsa_req_if.sink    req,
	ffsa_rsp_if.source  rsp
);

	localparam int FW = ffsa_pkg::FIELD_W;

	ffsa_pkg::ffsa_cmd_t  cmd;
	ffsa_pkg::ffsa_stat_t stat;
	logic [INDEX_BITS-1:0] dp_granted;
	ffsa_pkg::status_t     dp_status;
	logic                  rsp_failed;

	ffsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ffsa_datapath #(
		.MAX_SPANS  (MAX_SPANS),
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_mode    (req.mode),
		.req_start   (INDEX_BITS'(req.span_start)),
		.req_length  (INDEX_BITS'(req.span_length)),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_granted (dp_granted),
		.rsp_status  (dp_status)
	);

	assign rsp.granted_start = FW'(dp_granted);
	assign rsp.status        = dp_status;

	// flag a response that reports a failure
	assign rsp_failed = rsp.valid && (rsp.status != ffsa_pkg::ST_OK);

	// one request in flight: ready drops right after a transaction
	`FFSA_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while busy")
	// a failed request never carries a grant
	`FFSA_ASSERT_IMP(a_fail_no_grant, rsp_failed, rsp.granted_start == '0, "grant on failure")
	// a response appears only after the controller asked to load it
	`FFSA_ASSERT_IMP(a_rsp_from_load, $rose(rsp.valid), $past(cmd.load_out), "response without load")

endmodule

// ===== design/ffsa_ctrl.sv =====
// Controller state machine sequencing scan, update and response
module ffsa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output ffsa_pkg::ffsa_cmd_t   cmd,
	input  ffsa_pkg::ffsa_stat_t  stat
);

	ffsa_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ffsa_pkg::S_IDLE: begin
				if (in_valid) state_d = ffsa_pkg::S_SCAN;
			end
			ffsa_pkg::S_SCAN: begin
				if (stat.bypass) state_d = ffsa_pkg::S_RESP;
				else if (stat.scan_done) state_d = ffsa_pkg::S_DECIDE;
			end
			ffsa_pkg::S_DECIDE: begin
				state_d = ffsa_pkg::S_APPLY;
			end
			ffsa_pkg::S_APPLY: begin
				unique case (stat.act) inside
					ffsa_pkg::ACT_WRITE_DEL, ffsa_pkg::ACT_DEL: state_d = ffsa_pkg::S_SHIFT_DN;
					ffsa_pkg::ACT_INS:                          state_d = ffsa_pkg::S_SHIFT_UP;
					default:                                    state_d = ffsa_pkg::S_RESP;
				endcase
			end
			ffsa_pkg::S_SHIFT_DN, ffsa_pkg::S_SHIFT_UP: begin
				if (stat.shift_done) state_d = ffsa_pkg::S_RESP;
			end
			ffsa_pkg::S_RESP: begin
				if (stat.out_free) state_d = ffsa_pkg::S_IDLE;
			end
			default: state_d = ffsa_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ffsa_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ffsa_pkg::S_SCAN:     cmd.scan     = 1'b1;
			ffsa_pkg::S_DECIDE:   cmd.decide   = 1'b1;
			ffsa_pkg::S_APPLY:    cmd.apply    = 1'b1;
			ffsa_pkg::S_SHIFT_DN: cmd.shift_dn = 1'b1;
			ffsa_pkg::S_SHIFT_UP: cmd.shift_up = 1'b1;
			ffsa_pkg::S_RESP:     cmd.load_out = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== design/ffsa_datapath.sv =====
// Span table memory, scan pipeline, merge arithmetic and result register
module ffsa_datapath #(
	parameter int MAX_SPANS  = 64,
	parameter int INDEX_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ffsa_pkg::ffsa_cmd_t    cmd,
	output ffsa_pkg::ffsa_stat_t   stat,
	input  logic                   req_mode,
	input  logic [INDEX_BITS-1:0]  req_start,
	input  logic [INDEX_BITS-1:0]  req_length,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [INDEX_BITS-1:0]  rsp_granted,
	output ffsa_pkg::status_t      rsp_status
);

	localparam int AW = $clog2(MAX_SPANS);
	localparam int CW = $clog2(MAX_SPANS + 1);
	localparam int IB = INDEX_BITS;
	localparam int EW = 2 * INDEX_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SPANS);
	localparam logic [CW-1:0] ONE     = CW'(1);

	// span table: {start, length} per entry
	logic [EW-1:0] mem [MAX_SPANS];

	ffsa_pkg::mode_t   mode_q;
	logic [IB-1:0]     s_q, len_q;
	logic [CW-1:0]     used_q, k_q, pos_q;
	logic              found_q;
	logic              dv_s1;
	logic [CW-1:0]     idx_s1;
	logic [EW-1:0]     rdata_s1;
	logic [IB-1:0]     prev_s_q, prev_l_q, cur_s_q, cur_l_q;
	ffsa_pkg::act_t    act_q;
	logic [CW-1:0]     wr_idx_q;
	logic [IB-1:0]     wr_s_q, wr_l_q;
	logic [IB-1:0]     granted_q;
	ffsa_pkg::status_t status_q;
	logic              out_valid_q;
	logic [IB-1:0]     out_granted_q;
	ffsa_pkg::status_t out_status_q;

	logic [IB-1:0] rd_s, rd_l;
	logic          hit_cond, chk_hit, chk_end;
	logic          rd_en;
	logic [CW-1:0] rd_idx;
	logic          walk_done;
	logic          we;
	logic [CW-1:0] wa;
	logic [EW-1:0] wd;
	logic          out_free;

	// merge arithmetic
	logic [IB:0]   prev_end, new_end, sum_pl, sum_nl;
	logic [IB+1:0] sum_all;
	logic          has_prev, tp, tn_adj, tn, tb;

	assign rd_s = rdata_s1[EW-1:IB];
	assign rd_l = rdata_s1[IB-1:0];

	// allocate stops at the first span long enough, free at the first start not below
	assign hit_cond = (mode_q == ffsa_pkg::MODE_ALLOC) ? (rd_l >= len_q) : (rd_s >= s_q);
	assign chk_hit  = cmd.scan && dv_s1 && hit_cond;
	assign chk_end  = cmd.scan && dv_s1 && !hit_cond && (idx_s1 == used_q - ONE);

	// read issue for scan and both shift directions
	always_comb begin
		rd_en  = 1'b0;
		rd_idx = k_q;
		if (cmd.scan || cmd.shift_dn) begin
			rd_en = (k_q < used_q);
		end else if (cmd.shift_up) begin
			rd_en  = (k_q > pos_q);
			rd_idx = k_q - ONE;
		end
	end

	assign walk_done = !dv_s1 && (cmd.shift_up ? (k_q == pos_q) : (k_q >= used_q));

	assign prev_end = {1'b0, prev_s_q} + {1'b0, prev_l_q};
	assign new_end  = {1'b0, s_q} + {1'b0, len_q};
	assign sum_pl   = {1'b0, prev_l_q} + {1'b0, len_q};
	assign sum_nl   = {1'b0, len_q} + {1'b0, cur_l_q};
	assign sum_all  = {2'b00, prev_l_q} + {2'b00, len_q} + {2'b00, cur_l_q};
	assign has_prev = (pos_q != '0);
	assign tp       = has_prev && (prev_end == {1'b0, s_q}) && !sum_pl[IB];
	assign tn_adj   = found_q && (new_end == {1'b0, cur_s_q});
	assign tn       = tn_adj && !sum_nl[IB];
	assign tb       = tn_adj && (sum_all[IB+1:IB] == 2'b00);

	// single write port: update, shift moves, final insert
	always_comb begin
		we = 1'b0;
		wa = wr_idx_q;
		wd = {wr_s_q, wr_l_q};
		if (cmd.apply && (act_q == ffsa_pkg::ACT_WRITE || act_q == ffsa_pkg::ACT_WRITE_DEL)) begin
			we = 1'b1;
		end else if (cmd.shift_dn && dv_s1) begin
			we = 1'b1;
			wa = idx_s1 - ONE;
			wd = rdata_s1;
		end else if (cmd.shift_up && dv_s1) begin
			we = 1'b1;
			wa = idx_s1 + ONE;
			wd = rdata_s1;
		end else if (cmd.shift_up && walk_done) begin
			we = 1'b1;
		end
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa[AW-1:0]] <= wd;
		if (rd_en) rdata_s1 <= mem[rd_idx[AW-1:0]];
		idx_s1 <= rd_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
		end else begin
			dv_s1 <= rd_en;
		end
	end

	// request capture, scan tracking, decision
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= ffsa_pkg::mode_t'(req_mode);
			s_q       <= req_start;
			len_q     <= req_length;
			k_q       <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			granted_q <= '0;
			status_q  <= ffsa_pkg::ST_OK;
		end else if (cmd.decide) begin
			wr_idx_q <= pos_q;
			wr_s_q   <= s_q;
			wr_l_q   <= len_q;
			k_q      <= pos_q + ONE;
			if (mode_q == ffsa_pkg::MODE_ALLOC) begin
				if (!found_q) begin
					status_q <= ffsa_pkg::ST_NO_FIT;
				end else begin
					granted_q <= cur_s_q;
					wr_s_q    <= cur_s_q + len_q;
					wr_l_q    <= cur_l_q - len_q;
				end
			end else if (tp) begin
				wr_idx_q <= pos_q - ONE;
				wr_s_q   <= prev_s_q;
				wr_l_q   <= (found_q && tb) ? sum_all[IB-1:0] : sum_pl[IB-1:0];
			end else if (tn) begin
				wr_l_q <= sum_nl[IB-1:0];
			end else if (used_q == MAX_CNT) begin
				status_q <= ffsa_pkg::ST_TABLE_FULL;
			end else begin
				k_q <= used_q;
			end
		end else begin
			if (rd_en) begin
				k_q <= cmd.shift_up ? (k_q - ONE) : (k_q + ONE);
			end
			if (cmd.scan && dv_s1) begin
				if (hit_cond) begin
					found_q <= 1'b1;
					pos_q   <= idx_s1;
					cur_s_q <= rd_s;
					cur_l_q <= rd_l;
				end else begin
					prev_s_q <= rd_s;
					prev_l_q <= rd_l;
					if (chk_end) pos_q <= used_q;
				end
			end
		end
	end

	// chosen action and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= ffsa_pkg::ACT_NONE;
			used_q <= '0;
		end else begin
			if (cmd.decide) begin
				if (mode_q == ffsa_pkg::MODE_ALLOC) begin
					if (!found_q) act_q <= ffsa_pkg::ACT_NONE;
					else if (cur_l_q == len_q) act_q <= ffsa_pkg::ACT_DEL;
					else act_q <= ffsa_pkg::ACT_WRITE;
				end else if (tp) begin
					act_q <= tb ? ffsa_pkg::ACT_WRITE_DEL : ffsa_pkg::ACT_WRITE;
				end else if (tn) begin
					act_q <= ffsa_pkg::ACT_WRITE;
				end else if (used_q == MAX_CNT) begin
					act_q <= ffsa_pkg::ACT_NONE;
				end else begin
					act_q <= ffsa_pkg::ACT_INS;
				end
			end
			if (cmd.shift_dn && walk_done) used_q <= used_q - ONE;
			else if (cmd.shift_up && walk_done) used_q <= used_q + ONE;
		end
	end

	// output register
	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out && out_free) begin
			out_granted_q <= granted_q;
			out_status_q  <= status_q;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_granted = out_granted_q;
	assign rsp_status  = out_status_q;

	assign stat.bypass     = (mode_q == ffsa_pkg::MODE_FREE) && (len_q == '0);
	assign stat.scan_done  = (used_q == '0) || chk_hit || chk_end;
	assign stat.act        = act_q;
	assign stat.shift_done = walk_done;
	assign stat.out_free   = out_free;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the first-fit span allocator core
`timescale 1ns / 1ps

module tb;

	localparam int          SPAN_SLOTS   = 64;
	localparam int          ITEM_TARGET  = 1750;
	localparam int          LIMIT_CYCLES = 2000000;
	localparam int          LONG_HOLD    = 500;

	typedef logic [ffsa_pkg::FIELD_W-1:0] idx_t;
	localparam idx_t        IDX_MASK     = '1;

	typedef struct packed {
		idx_t              granted;
		ffsa_pkg::status_t status;
	} span_rsp_t;

	typedef struct packed {
		idx_t s;
		idx_t l;
	} held_span_t;

	// Free-span table mirror plus the responses still owed by the block
	class span_ledger_t;
		idx_t        free_start[SPAN_SLOTS];
		idx_t        free_len[SPAN_SLOTS];
		int unsigned used;
		span_rsp_t   owed_rsp[$];
		int unsigned fail_count;

		function new();
			used = 0;
			fail_count = 0;
		endfunction

		// End compared at full precision; merged length must fit the index width
		function bit spans_abut(idx_t s0, idx_t l0, idx_t s1, idx_t l1);
			logic [ffsa_pkg::FIELD_W:0] end0;
			logic [ffsa_pkg::FIELD_W:0] sum;
			end0 = {1'b0, s0} + {1'b0, l0};
			sum  = {1'b0, l0} + {1'b0, l1};
			return (end0 == {1'b0, s1}) && (sum <= {1'b0, IDX_MASK});
		endfunction

		function void remove_entry(int unsigned i);
			for (int unsigned j = i; j + 1 < used; j++) begin
				free_start[j] = free_start[j + 1];
				free_len[j]   = free_len[j + 1];
			end
			used--;
		endfunction

		// First fit: drop an exact match, else shrink the first larger span from its front
		function ffsa_pkg::status_t first_fit_take(idx_t len, output idx_t granted);
			granted = '0;
			for (int unsigned i = 0; i < used; i++) begin
				if (free_len[i] == len) begin
					granted = free_start[i];
					remove_entry(i);
					return ffsa_pkg::ST_OK;
				end
				if (free_len[i] > len) begin
					granted       = free_start[i];
					free_start[i] = free_start[i] + len;
					free_len[i]   = free_len[i] - len;
					return ffsa_pkg::ST_OK;
				end
			end
			return ffsa_pkg::ST_NO_FIT;
		endfunction

		// Sorted insert with coalescing into the previous and the following span
		function ffsa_pkg::status_t release_span(idx_t s, idx_t len);
			int unsigned pos;
			if (len == 0)
				return ffsa_pkg::ST_OK;
			pos = 0;
			while (pos < used && free_start[pos] < s)
				pos++;
			if (pos > 0 && spans_abut(free_start[pos-1], free_len[pos-1], s, len)) begin
				free_len[pos-1] = free_len[pos-1] + len;
				if (pos < used && spans_abut(free_start[pos-1], free_len[pos-1],
						free_start[pos], free_len[pos])) begin
					free_len[pos-1] = free_len[pos-1] + free_len[pos];
					remove_entry(pos);
				end
				return ffsa_pkg::ST_OK;
			end
			if (pos < used && spans_abut(s, len, free_start[pos], free_len[pos])) begin
				free_start[pos] = s;
				free_len[pos]   = free_len[pos] + len;
				return ffsa_pkg::ST_OK;
			end
			if (used >= SPAN_SLOTS)
				return ffsa_pkg::ST_TABLE_FULL;
			for (int j = int'(used); j > int'(pos); j--) begin
				free_start[j] = free_start[j-1];
				free_len[j]   = free_len[j-1];
			end
			free_start[pos] = s;
			free_len[pos]   = len;
			used++;
			return ffsa_pkg::ST_OK;
		endfunction

		// Note an accepted request: update the mirror and queue the owed response
		function span_rsp_t note_request(ffsa_pkg::mode_t m, idx_t s, idx_t l);
			span_rsp_t r;
			idx_t      g;
			r.granted = '0;
			if (m == ffsa_pkg::MODE_ALLOC) begin
				r.status = first_fit_take(l, g);
				if (r.status == ffsa_pkg::ST_OK)
					r.granted = g;
			end else begin
				r.status = release_span(s, l);
			end
			owed_rsp.push_back(r);
			return r;
		endfunction

		// Compare one response transaction against the oldest owed response
		function void check_response(idx_t g, logic [ffsa_pkg::STATUS_W-1:0] st);
			span_rsp_t want;
			if (owed_rsp.size() == 0) begin
				$display("%0t: unexpected response granted_start %h status %0d", $time, g, st);
				fail_count++;
				return;
			end
			want = owed_rsp.pop_front();
			if (g !== want.granted) begin
				$display("%0t: granted_start expected %h actual %h", $time, want.granted, g);
				fail_count++;
			end
			if (st !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
				fail_count++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	span_ledger_t ledger;
	int unsigned  items_sent = 0;
	int unsigned  cycle_count = 0;
	bit           req_up = 1'b0;
	bit           brisk_send = 1'b0;
	int unsigned  hold_requests = 0;
	int unsigned  hold_taken = 0;
	bit           rsp_brisk = 1'b0;
	int unsigned  rsp_stall_left = 0;
	int unsigned  rsp_hold_left = 0;
	held_span_t   held[$];

	ffsa_req_if req_ch();
	ffsa_rsp_if rsp_ch();

	first_fit_span_allocator_core #(
		.MAX_SPANS (SPAN_SLOTS),
		.INDEX_BITS(ffsa_pkg::FIELD_W)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Response side: check each transaction, then stall, hold off or accept
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				ledger.check_response(rsp_ch.granted_start, rsp_ch.status);
				rsp_stall_left = rsp_brisk ? 0 : $urandom_range(0, 11);
				if ($urandom_range(0, 39) == 0)
					rsp_brisk = !rsp_brisk;
			end
			if (hold_taken != hold_requests) begin
				hold_taken = hold_requests;
				rsp_hold_left = LONG_HOLD;
			end
			if (rsp_hold_left != 0) begin
				rsp_hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_stall_left != 0) begin
				rsp_stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one request after a random gap and wait for its transaction
	task automatic send_request(input ffsa_pkg::mode_t m, input idx_t s, input idx_t l,
			output span_rsp_t exp_rsp);
		int unsigned gap;
		gap = brisk_send ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			if (req_up) begin
				req_ch.valid <= 1'b0;
				req_up = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.mode        <= m;
		req_ch.span_start  <= s;
		req_ch.span_length <= l;
		req_up = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		exp_rsp = ledger.note_request(m, s, l);
		items_sent++;
	endtask

	// Hold the request side until every owed response has arrived
	task automatic wait_all_answered();
		if (req_up) begin
			req_ch.valid <= 1'b0;
			req_up = 1'b0;
			@(posedge clk);
		end
		while (ledger.owed_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Empty the table by allocating the exact length of the first span
	task automatic drain_table();
		span_rsp_t r;
		while (ledger.used != 0)
			send_request(ffsa_pkg::MODE_ALLOC, idx_t'($urandom), ledger.free_len[0], r);
	endtask

	// Empty the table, fill it with spaced spans in random order, overflow it, extend some, empty it again
	task automatic fill_phase();
		idx_t      base;
		idx_t      stride;
		int        order[$];
		int        pick;
		int        i;
		span_rsp_t r;
		drain_table();
		base   = $urandom_range(0, 24'h800000);
		stride = $urandom_range(4, 2000);
		for (int k = 0; k < SPAN_SLOTS + 6; k++)
			order.push_back(k);
		while (order.size() != 0) begin
			pick = $urandom_range(0, order.size() - 1);
			send_request(ffsa_pkg::MODE_FREE, base + idx_t'(order[pick]) * stride,
				$urandom_range(1, stride - 2), r);
			order.delete(pick);
		end
		repeat (4) begin
			i = $urandom_range(0, ledger.used - 1);
			send_request(ffsa_pkg::MODE_FREE, ledger.free_start[i] + ledger.free_len[i], 1, r);
		end
		drain_table();
	endtask

	// Allocate and free within a region, then give back everything still held
	task automatic churn_phase();
		idx_t      base;
		idx_t      size;
		idx_t      l;
		int        pick;
		span_rsp_t r;
		if (ledger.used > 40)
			drain_table();
		base = $urandom_range(0, 24'hFF0000);
		size = $urandom_range(64, 4096);
		send_request(ffsa_pkg::MODE_FREE, base, size, r);
		repeat ($urandom_range(20, 50)) begin
			if (held.size() == 0 || $urandom_range(0, 99) < 55) begin
				case ($urandom_range(0, 9))
					0: begin
						l = '0;
					end
					1: begin
						l = $urandom_range(size / 2, size + 8);
					end
					default: begin
						l = $urandom_range(1, 48);
					end
				endcase
				send_request(ffsa_pkg::MODE_ALLOC, idx_t'($urandom), l, r);
				if (r.status == ffsa_pkg::ST_OK && l != 0)
					held.push_back('{r.granted, l});
			end else begin
				pick = $urandom_range(0, held.size() - 1);
				send_request(ffsa_pkg::MODE_FREE, held[pick].s, held[pick].l, r);
				held.delete(pick);
			end
		end
		while (held.size() != 0) begin
			pick = $urandom_range(0, held.size() - 1);
			send_request(ffsa_pkg::MODE_FREE, held[pick].s, held[pick].l, r);
			held.delete(pick);
		end
	endtask

	// Unstructured requests with fields of random magnitude
	task automatic noise_phase();
		ffsa_pkg::mode_t m;
		idx_t            s;
		idx_t            l;
		span_rsp_t       r;
		repeat ($urandom_range(10, 30)) begin
			m = ffsa_pkg::mode_t'($urandom_range(0, 1));
			s = idx_t'($urandom) >> $urandom_range(0, 23);
			l = idx_t'($urandom) >> $urandom_range(0, 23);
			send_request(m, s, l, r);
		end
	endtask

	initial begin : stimulus
		span_rsp_t r;
		int        sel;
		ledger = new();
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.mode        <= ffsa_pkg::MODE_ALLOC;
		req_ch.span_start  <= '0;
		req_ch.span_length <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, zero lengths
		send_request(ffsa_pkg::MODE_ALLOC, 24'h000000, 24'h000005, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'hFFFFFF, 24'h000000, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h000100, 24'h000000, r);
		// merge with both neighbours, then with the following one only
		send_request(ffsa_pkg::MODE_FREE,  24'h000000, 24'h000100, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h000200, 24'h000100, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h000100, 24'h000100, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h000400, 24'h000010, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h0003F0, 24'h000010, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'h123456, 24'h000000, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'h000000, 24'h000300, r);
		// span end beyond the index range, exact fit of the largest length
		send_request(ffsa_pkg::MODE_FREE,  24'hFFFFF0, 24'hFFFFFF, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h000000, 24'h000010, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'h000000, 24'hFFFFFF, r);
		// start wraps when a span near the top is shrunk
		send_request(ffsa_pkg::MODE_FREE,  24'hFFFFF0, 24'h000100, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'h000000, 24'h000020, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'h000000, 24'h0000E0, r);
		// merge that would overflow, then a double free
		send_request(ffsa_pkg::MODE_FREE,  24'h000010, 24'hFFFFF0, r);
		send_request(ffsa_pkg::MODE_FREE,  24'h000000, 24'h000010, r);
		send_request(ffsa_pkg::MODE_FREE,  24'hFFFFFF, 24'hFFFFFF, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'hFFFFFF, 24'hFFFFFF, r);
		send_request(ffsa_pkg::MODE_ALLOC, 24'hFFFFFF, 24'h000001, r);
		wait_all_answered();
		drain_table();

		// overflow the table while the response side holds off
		hold_requests++;
		fill_phase();
		wait_all_answered();

		while (items_sent < ITEM_TARGET) begin
			brisk_send = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				hold_requests++;
			sel = $urandom_range(0, 19);
			if (sel == 0)
				fill_phase();
			else if (sel < 4)
				noise_phase();
			else
				churn_phase();
			if ($urandom_range(0, 5) == 0)
				wait_all_answered();
		end

		wait_all_answered();
		repeat (2 * SPAN_SLOTS + 20) @(posedge clk);
		if (ledger.fail_count == 0 && ledger.owed_rsp.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
